// ----- hdl/dcmg_pkg.sv -----
// ----------------------------------------------------------------------------
// Diamond-cell mask generator package
// Shared constants, the configuration register index type and the sequencer state type of the mask generator.
// ----------------------------------------------------------------------------
package dcmg_pkg;

  // Pattern geometry.
  localparam int unsigned CellSize  = 64;
  localparam int unsigned CellShift = $clog2(CellSize);
  localparam int unsigned RowWeight = 5;

  // Field and register widths.
  localparam int unsigned CoordW = 12;
  localparam int unsigned DimW   = 13;
  localparam int unsigned PixW   = 8;
  localparam int unsigned DvdW   = 2 * PixW;

  // Register reset values.
  localparam logic [DimW-1:0] WidthReset  = 13'd512;
  localparam logic [DimW-1:0] HeightReset = 13'd256;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_OUT
  } dcmg_state_e;

endpackage

// ----- hdl/diamond_cell_mask_generator.sv -----
// Sequence: a measure pixel passes through the pattern state and then the
// output state; an emit pixel with a nonzero maximum passes through the
// pattern state, the radix-4 divider steps and the output state; emit with
// a zero maximum skips the divider. Flow: one pixel at a time; the next
// transfer is taken in the cycle after the result transfer.
// Reset: asynchronous, active low; clears the running maximum and the
// sequencer and loads frame height 256 (frame width affects no result).
// ----------------------------------------------------------------------------
// Diamond-cell mask generator
// Computes the diamond-cell pattern value of a pixel, tracks the frame
// maximum in the measure pass and normalizes against it in the emit pass
// with a two-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
module diamond_cell_mask_generator
  import dcmg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration write port
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_index_i,
  input  logic [DimW-1:0]   cfg_data_i,
  // Input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic              restart_max_i,
  input  logic [CoordW-1:0] pixel_x_i,
  input  logic [CoordW-1:0] pixel_y_i,
  // Output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [PixW-1:0]   raw_value_o,
  output logic [PixW-1:0]   gray_level_o,
  output logic              opaque_o,
  output logic [CoordW-1:0] memory_row_o
);

  localparam int unsigned CntW = $clog2(DvdW / 2);
  localparam int unsigned JW   = DimW + 2;
  localparam int unsigned RowW = 11;
  localparam int unsigned KW   = DimW - CellShift + 1;

  dcmg_state_e state_q, state_d;

  logic [DimW-1:0]   height_q;
  logic [PixW-1:0]   max_q;
  logic              act_q, restart_q;
  logic [CoordW-1:0] x_q, y_q;
  logic [PixW-1:0]   raw_q, gray_q;
  logic              opaque_q;
  logic [CoordW-1:0] mrow_q;
  logic [DvdW-1:0]   dvd_q;
  logic [PixW-1:0]   rem_q;
  logic [PixW-1:0]   quo_q;
  logic [CntW-1:0]   cnt_q;

  logic in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // Configuration registers; a frame width write is accepted but changes nothing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_FRAME_WIDTH:  ;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Flipped memory row, registered in the pattern cycle.
  logic [DimW-1:0] mrow_full;
  assign mrow_full = height_q - DimW'(1) - {1'b0, y_q};

  // Pattern value: rotate the coordinates and split them into cells.
  logic [KW-1:0]          k;
  logic [DimW-1:0]        i_sum;
  logic signed [JW-1:0]   j_sum;
  logic                   j_neg;
  logic [JW-1:0]          j_abs;
  logic [CellShift-1:0]   ri, rj;
  logic signed [RowW-1:0] cj, row;
  logic [CellShift:0]     di, dj, dm;
  logic [PixW-1:0]        raw;
  logic [PixW-1:0]        row_lo;

  always_comb begin
    k      = KW'(height_q[DimW-1:CellShift]) + KW'(1);
    i_sum  = {1'b0, x_q} + {1'b0, y_q};
    j_sum  = $signed({3'b000, x_q}) - $signed({3'b000, y_q})
           + $signed(JW'({k, {CellShift{1'b0}}}));
    j_neg  = j_sum[JW-1];
    j_abs  = j_neg ? JW'(-j_sum) : JW'(j_sum);
    ri     = i_sum[CellShift-1:0];
    rj     = j_abs[CellShift-1:0];
    // Truncating division toward zero for a negative rotated column.
    cj     = j_neg ? -$signed(RowW'(j_abs[JW-1:CellShift]))
                   :  $signed(RowW'(j_abs[JW-1:CellShift]));
    row    = $signed(RowW'(i_sum[DimW-1:CellShift])) - cj + $signed(RowW'(k));
    // Distance from the cell center along each rotated axis.
    di     = (ri <= CellShift'(CellSize / 2)) ? (CellShift + 1)'(CellSize / 2 - ri)
                                              : (CellShift + 1)'(ri - CellSize / 2);
    if (j_neg) begin
      dj = (CellShift + 1)'(rj) + (CellShift + 1)'(CellSize / 2);
    end else begin
      dj = (rj <= CellShift'(CellSize / 2)) ? (CellShift + 1)'(CellSize / 2 - rj)
                                            : (CellShift + 1)'(rj - CellSize / 2);
    end
    dm     = (di > dj) ? di : dj;
    row_lo = row[PixW-1:0];
    raw    = PixW'(row_lo * PixW'(RowWeight)) + PixW'(dm);
  end

  // One radix-4 step of the restoring divider.
  logic [PixW:0]   r1, r2;
  logic [PixW-1:0] r1_n, r2_n;
  logic            b1, b2;

  always_comb begin
    r1   = {rem_q, dvd_q[DvdW-1]};
    b1   = (r1 >= {1'b0, max_q});
    r1_n = b1 ? PixW'(r1 - {1'b0, max_q}) : r1[PixW-1:0];
    r2   = {r1_n, dvd_q[DvdW-2]};
    b2   = (r2 >= {1'b0, max_q});
    r2_n = b2 ? PixW'(r2 - {1'b0, max_q}) : r2[PixW-1:0];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_xfer) state_d = S_CALC;
      S_CALC: state_d = (act_q && (max_q != '0)) ? S_DIV : S_OUT;
      S_DIV:  if (cnt_q == CntW'(DvdW / 2 - 1)) state_d = S_OUT;
      S_OUT:  if (out_xfer) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Running maximum, updated only by measure pixels.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
    end else if (state_q == S_CALC && !act_q) begin
      if (restart_q || raw > max_q) begin
        max_q <= raw;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          act_q     <= action_i;
          restart_q <= restart_max_i;
          x_q       <= pixel_x_i;
          y_q       <= pixel_y_i;
        end
      end
      S_CALC: begin
        raw_q    <= raw;
        opaque_q <= (row != '0);
        mrow_q   <= mrow_full[CoordW-1:0];
        gray_q   <= '0;
        dvd_q    <= {raw, {PixW{1'b0}}} - DvdW'(raw);
        rem_q    <= '0;
        quo_q    <= '0;
        cnt_q    <= '0;
      end
      S_DIV: begin
        dvd_q <= {dvd_q[DvdW-3:0], 2'b00};
        rem_q <= r2_n;
        quo_q <= {quo_q[PixW-3:0], b1, b2};
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DvdW / 2 - 1)) begin
          gray_q <= {quo_q[PixW-3:0], b1, b2};
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign raw_value_o  = raw_q;
  assign gray_level_o = gray_q;
  assign opaque_o     = opaque_q;
  assign memory_row_o = mrow_q;

`ifndef SYNTH
  // No new transfer is taken while a result is offered.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

  // An input transfer always starts the pattern cycle.
  a_accept_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_CALC))
    else $error("input transfer did not start calculation");

  // Emit pixels never touch the running maximum.
  a_emit_keeps_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC && act_q) |=> $stable(max_q))
    else $error("emit pass changed the maximum");

  // The partial remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < max_q))
    else $error("divider remainder out of range");

  // Measure results carry a zero gray level.
  a_measure_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !act_q) |-> (gray_level_o == '0))
    else $error("measure result with nonzero gray level");
`endif

endmodule

// ----- tb/diamond_cell_mask_generator_test.sv -----
// ----------------------------------------------------------------------------
// Diamond-cell mask generator testbench
// Drives measure and emit passes of random pixels through the mask generator
// under several frame sizes, with random gaps on the input side and random
// stalls on the output side. A scoreboard predicts every result and checks
// it field by field.
// ----------------------------------------------------------------------------
module diamond_cell_mask_generator_test;
  import dcmg_pkg::*;

  localparam int CellPitch     = int'(CellSize);
  localparam int PatternWeight = int'(RowWeight);
  localparam int NumSettings   = 8;
  localparam int PixelsPerSize = 150;
  localparam int CycleLimit    = 1000000;

  // One result of the block as it appears on the output channel.
  typedef struct packed {
    logic [PixW-1:0]   raw;
    logic [PixW-1:0]   gray;
    logic              opaque;
    logic [CoordW-1:0] mem_row;
  } mask_result_t;

  // Predicts the pattern of each accepted pixel and checks the results.
  class mask_scoreboard;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic [PixW-1:0] peak;
    mask_result_t    pending[$];
    int errors;
    int measures;
    int emits;
    int zero_peak_emits;
    int above_peak_emits;
    int clear_pixels;

    function new();
      width            = WidthReset;
      height           = HeightReset;
      peak             = '0;
      errors           = 0;
      measures         = 0;
      emits            = 0;
      zero_peak_emits  = 0;
      above_peak_emits = 0;
      clear_pixels     = 0;
    endfunction

    function void set_register(reg_idx_e idx, logic [DimW-1:0] value);
      if (idx == REG_FRAME_WIDTH) begin
        width = value;
      end else begin
        height = value;
      end
    endfunction

    // Rotates the pixel into diamond cells and works out its expected result.
    function void note_pixel(logic emit, logic restart, logic [CoordW-1:0] x,
                             logic [CoordW-1:0] y);
      int h, k, diag_i, diag_j, cell_i, cell_j, row, dist_i, dist_j, dist_max;
      mask_result_t res;
      h      = int'(height);
      k      = h / CellPitch + 1;
      diag_i = int'(x) + int'(y);
      diag_j = int'(x) - int'(y) + k * CellPitch;
      cell_i = diag_i / CellPitch;
      cell_j = diag_j / CellPitch;
      row    = cell_i - cell_j + k;
      dist_i = cell_i * CellPitch - diag_i + CellPitch / 2;
      dist_j = cell_j * CellPitch - diag_j + CellPitch / 2;
      if (dist_i < 0) dist_i = -dist_i;
      if (dist_j < 0) dist_j = -dist_j;
      dist_i   = dist_i & 255;
      dist_j   = dist_j & 255;
      dist_max = (dist_i > dist_j) ? dist_i : dist_j;

      res.raw     = 8'(row * PatternWeight + dist_max);
      res.gray    = '0;
      res.opaque  = (row != 0);
      res.mem_row = 12'(h - 1 - int'(y));

      if (!emit) begin
        measures++;
        if (restart) peak = '0;
        if (res.raw > peak) peak = res.raw;
      end else begin
        emits++;
        if (peak == 0) begin
          zero_peak_emits++;
        end else begin
          // A value above the maximum wraps the quotient to eight bits.
          if (res.raw > peak) above_peak_emits++;
          res.gray = 8'((int'(res.raw) * 255) / int'(peak));
        end
      end
      if (!res.opaque) clear_pixels++;
      pending.push_back(res);
    endfunction

    function void check_result(mask_result_t got);
      mask_result_t want;
      if (pending.size() == 0) begin
        $error("result transfer with no pixel outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.raw != want.raw) begin
        $error("raw_value: expected %0d, actual %0d", want.raw, got.raw);
        errors++;
      end
      if (got.gray != want.gray) begin
        $error("gray_level: expected %0d, actual %0d", want.gray, got.gray);
        errors++;
      end
      if (got.opaque != want.opaque) begin
        $error("opaque: expected %0d, actual %0d", want.opaque, got.opaque);
        errors++;
      end
      if (got.mem_row != want.mem_row) begin
        $error("memory_row: expected %0d, actual %0d", want.mem_row, got.mem_row);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [0:0]        cfg_index_i   = '0;
  logic [DimW-1:0]   cfg_data_i    = '0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic              action_i      = 1'b0;
  logic              restart_max_i = 1'b0;
  logic [CoordW-1:0] pixel_x_i     = '0;
  logic [CoordW-1:0] pixel_y_i     = '0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [PixW-1:0]   raw_value_o;
  logic [PixW-1:0]   gray_level_o;
  logic              opaque_o;
  logic [CoordW-1:0] memory_row_o;

  mask_scoreboard sb;
  bit             quiet       = 1'b0;
  int             stall_left  = 0;
  int             cycle_count = 0;
  int             pixels_sent = 0;

  diamond_cell_mask_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .restart_max_i (restart_max_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .raw_value_o   (raw_value_o),
    .gray_level_o  (gray_level_o),
    .opaque_o      (opaque_o),
    .memory_row_o  (memory_row_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // A coordinate inside a frame dimension, or anywhere if the frame is empty
  // or wider than the coordinate range.
  function automatic logic [CoordW-1:0] coord_in(logic [DimW-1:0] limit);
    if (limit == 0 || limit > 4096) return CoordW'($urandom_range(0, 4095));
    return CoordW'($urandom_range(0, int'(limit) - 1));
  endfunction

  // Watch both channels and hand every transfer to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_pixel(action_i, restart_max_i, pixel_x_i, pixel_y_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{raw: raw_value_o, gray: gray_level_o, opaque: opaque_o,
                        mem_row: memory_row_o});
    end
  end

  // Random output stalls; no new stall starts during quiet stretches.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("diamond_cell_mask_generator_test failed");
      $finish;
    end
  end

  // Presents one pixel after a random gap (none during quiet stretches) and waits for its transfer.
  task automatic send_pixel(input logic emit, input logic restart,
                            input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= emit;
    restart_max_i <= restart;
    pixel_x_i     <= x;
    pixel_y_i     <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pixels_sent++;
  endtask

  // Lets every outstanding pixel come out before a register write. The first
  // edge makes sure the last input transfer has reached the scoreboard.
  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_frame_size(input logic [DimW-1:0] w, input logic [DimW-1:0] h);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_FRAME_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    sb.set_register(REG_FRAME_WIDTH, w);
    cfg_index_i <= REG_FRAME_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    sb.set_register(REG_FRAME_HEIGHT, h);
    cfg_we_i <= 1'b0;
  endtask

  // A pixel of the current frame most of the time, anywhere otherwise.
  task automatic send_frame_pixel(input logic emit, input logic restart);
    if ($urandom_range(0, 9) == 0) begin
      send_pixel(emit, restart, CoordW'($urandom), CoordW'($urandom));
    end else begin
      send_pixel(emit, restart, coord_in(sb.width), coord_in(sb.height));
    end
  endtask

  initial begin
    logic [DimW-1:0] widths[NumSettings];
    logic [DimW-1:0] heights[NumSettings];
    int target, count;
    widths  = '{1, 4096, 100, 8191, 640, 64, 4000, 0};
    heights = '{1, 4096, 70, 8191, 0, 64, 129, 256};
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pixels under the reset frame size: emit before any maximum,
    // restart requests in the emit pass, corner coordinates, alternating bit
    // patterns, a clear cell-row-zero pixel and a value above the maximum.
    send_pixel(1'b1, 1'b0, 12'd0, 12'd0);
    send_pixel(1'b1, 1'b1, 12'd4095, 12'd4095);
    send_pixel(1'b0, 1'b1, 12'd0, 12'd0);
    send_pixel(1'b0, 1'b0, 12'd4095, 12'd0);
    send_pixel(1'b0, 1'b0, 12'd0, 12'd4095);
    send_pixel(1'b0, 1'b0, 12'd4095, 12'd4095);
    send_pixel(1'b1, 1'b1, 12'd0, 12'd0);
    send_pixel(1'b1, 1'b0, 12'd4095, 12'd0);
    send_pixel(1'b1, 1'b0, 12'd0, 12'd4095);
    send_pixel(1'b1, 1'b0, 12'd4095, 12'd4095);
    send_pixel(1'b0, 1'b0, 12'hAAA, 12'h555);
    send_pixel(1'b1, 1'b0, 12'h555, 12'hAAA);
    send_pixel(1'b0, 1'b1, 12'd0, 12'd0);
    send_pixel(1'b1, 1'b0, 12'd0, 12'd63);
    send_pixel(1'b1, 1'b0, 12'd200, 12'd100);
    send_pixel(1'b0, 1'b1, 12'd2048, 12'd2048);
    send_pixel(1'b1, 1'b0, 12'd255, 12'd255);

    // Random frames: mostly a measure pass opened by a restart and followed
    // by an emit pass, with some unordered pixels mixed in.
    for (int s = 0; s < NumSettings; s++) begin
      wait_for_idle();
      write_frame_size(widths[s], heights[s]);
      target = pixels_sent + PixelsPerSize;
      while (pixels_sent < target) begin
        quiet = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 99) < 15) begin
          count = $urandom_range(1, 6);
          repeat (count) begin
            send_pixel(1'($urandom), 1'($urandom), CoordW'($urandom), CoordW'($urandom));
          end
        end else begin
          count = $urandom_range(1, 20);
          for (int n = 0; n < count; n++) begin
            send_frame_pixel(1'b0, n == 0 || $urandom_range(0, 19) == 0);
          end
          count = $urandom_range(1, 20);
          repeat (count) send_frame_pixel(1'b1, 1'($urandom_range(0, 9) == 0));
        end
      end
    end
    quiet = 1'b0;

    wait_for_idle();
    repeat (20) @(posedge clk_i);

    $display("Ran %0d pixels (%0d measure, %0d emit) over %0d frame sizes plus reset size.",
             pixels_sent, sb.measures, sb.emits, NumSettings);
    $display("Emits with zero maximum: %0d, above maximum: %0d; clear pixels: %0d.",
             sb.zero_peak_emits, sb.above_peak_emits, sb.clear_pixels);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("diamond_cell_mask_generator_test passed");
    end else begin
      $display("diamond_cell_mask_generator_test failed");
    end
    $finish;
  end

endmodule
